>>> rtl/cwmf_pkg.sv
// Package for the clipped window median filter.
// Holds field widths, register indexes, the queue entry type and defaults.
// No dependencies.
package cwmf_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;

  // Fixed widths of the stream fields and registers.
  localparam int COORD_W   = 6;
  localparam int PIX_W     = 8;
  localparam int WS_W      = 3;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE = 2'd0,
    CFG_IMAGE_ROWS  = 2'd1,
    CFG_IMAGE_COLS  = 2'd2
  } cfg_idx_t;

  // Classified item passed from the front to the back.
  // For a load, r0/c0 hold the pixel position and skip marks a position
  // outside the store. For a query, skip marks a coordinate error and
  // r0..r1, c0..c1 give the clipped window.
  typedef struct packed {
    logic               query;
    logic               skip;
    logic [COORD_W-1:0] r0;
    logic [COORD_W-1:0] r1;
    logic [COORD_W-1:0] c0;
    logic [COORD_W-1:0] c1;
    logic [PIX_W-1:0]   pixel;
  } cwmf_item_t;

endpackage

>>> rtl/cwmf_front.sv
// Front part: classifies one input item and works out its clipped window.
// Depends on cwmf_pkg.
module cwmf_front #(
  parameter int MAX_WINDOW = cwmf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_ROWS   = cwmf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = cwmf_pkg::MAX_COLS_DEF
) (
  input  logic [cwmf_pkg::WS_W-1:0]    window_size,
  input  logic [cwmf_pkg::DIM_W-1:0]   image_rows,
  input  logic [cwmf_pkg::DIM_W-1:0]   image_cols,
  input  logic                         action,
  input  logic [cwmf_pkg::COORD_W-1:0] row,
  input  logic [cwmf_pkg::COORD_W-1:0] col,
  input  logic [cwmf_pkg::PIX_W-1:0]   pixel,
  output cwmf_pkg::cwmf_item_t         item
);

  localparam int WIN_LIMIT = MAX_WINDOW | 1;
  localparam int DIM_W     = cwmf_pkg::DIM_W;

  logic [3:0]                   side;
  logic [2:0]                   half;
  logic [cwmf_pkg::DIM_W-1:0]   rows_used;
  logic [cwmf_pkg::DIM_W-1:0]   cols_used;
  logic [cwmf_pkg::DIM_W-1:0]   r_hi;
  logic [cwmf_pkg::DIM_W-1:0]   c_hi;

  // Window half width, odd side saturated at the limit.
  always_comb begin
    side = {1'b0, window_size} | 4'd1;
    if (int'(side) > WIN_LIMIT) begin
      side = 4'(WIN_LIMIT);
    end
    half = side[3:1];
  end

  // Image size in use, saturated at the store size.
  assign rows_used = (int'(image_rows) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : image_rows;
  assign cols_used = (int'(image_cols) > MAX_COLS) ? DIM_W'(MAX_COLS) : image_cols;

  // Upper window bounds clipped to the last row and column.
  always_comb begin
    r_hi = {1'b0, row} + {4'b0, half};
    if (r_hi > rows_used - 7'd1) begin
      r_hi = rows_used - 7'd1;
    end
    c_hi = {1'b0, col} + {4'b0, half};
    if (c_hi > cols_used - 7'd1) begin
      c_hi = cols_used - 7'd1;
    end
  end

  // Classification and window bounds.
  always_comb begin
    item.query = action;
    item.pixel = pixel;
    item.r1    = r_hi[5:0];
    item.c1    = c_hi[5:0];
    if (action) begin
      item.skip = ({1'b0, row} >= rows_used) || ({1'b0, col} >= cols_used);
      item.r0   = (row >= {3'b0, half}) ? row - {3'b0, half} : 6'd0;
      item.c0   = (col >= {3'b0, half}) ? col - {3'b0, half} : 6'd0;
    end else begin
      item.skip = (int'(row) >= MAX_ROWS) || (int'(col) >= MAX_COLS);
      item.r0   = row;
      item.c0   = col;
    end
  end

endmodule

>>> rtl/cwmf_queue.sv
// Short queue of classified items between the front and the back.
// Depends on cwmf_pkg.
module cwmf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cwmf_pkg::cwmf_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output cwmf_pkg::cwmf_item_t head
);

  localparam int DEPTH = cwmf_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  cwmf_pkg::cwmf_item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == (PW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && not_empty);
    end
  end

endmodule

>>> rtl/cwmf_back.sv
// Back part: frame store, window gather, insertion sorter and median pick.
// Depends on cwmf_pkg.
module cwmf_back #(
  parameter int MAX_WINDOW = cwmf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_ROWS   = cwmf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = cwmf_pkg::MAX_COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  cwmf_pkg::cwmf_item_t       q_item,
  output logic                       q_pop,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic [cwmf_pkg::PIX_W-1:0] m_median,
  output logic                       m_error
);

  localparam int WIN_LIMIT  = MAX_WINDOW | 1;
  localparam int GATHER_MAX = WIN_LIMIT * WIN_LIMIT;
  localparam int CNT_W      = $clog2(GATHER_MAX + 1);
  localparam int MEM_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int PW         = cwmf_pkg::PIX_W;
  localparam int CW         = cwmf_pkg::COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GATHER, ST_DRAIN, ST_SHIFT, ST_RESULT
  } state_t;

  state_t           state;
  logic [CW-1:0]    r, c, r0, c0, r1, c1;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] j;
  logic [PW-1:0]    lo;
  logic [PW-1:0]    med;
  logic             err;

  logic [PW-1:0]    mem [MEM_DEPTH];
  logic [PW-1:0]    rd_data;
  logic             rd_vld;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  logic [PW-1:0]    srt [GATHER_MAX];
  logic             srt_vld [GATHER_MAX];
  logic             gt [GATHER_MAX];
  logic             clear_sorter;
  logic             shifting;
  logic [CNT_W-1:0] mid;
  logic [PW:0]      sum;

  // Store addresses are row * MAX_COLS + col.
  assign rd_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
  assign wr_addr = AW'(q_item.r0) * AW'(MAX_COLS) + AW'(q_item.c0);
  assign wr_en   = (state == ST_IDLE) && q_valid && !q_item.query && !q_item.skip;
  assign rd_en   = (state == ST_GATHER);
  assign q_pop   = (state == ST_IDLE) && q_valid;

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_item.pixel;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // A sorter entry is above the new pixel if empty or holding a larger value.
  always_comb begin
    for (int i = 0; i < GATHER_MAX; i++) begin
      gt[i] = !srt_vld[i] || (srt[i] > rd_data);
    end
  end

  assign clear_sorter = (state == ST_IDLE);
  assign shifting     = (state == ST_SHIFT);

  // Insertion sorter: each entry keeps, takes the new pixel or takes its
  // lower neighbor. During the shift-out, entries move toward entry 0.
  always_ff @(posedge clk) begin
    for (int i = 0; i < GATHER_MAX; i++) begin
      if (shifting) begin
        if (i < GATHER_MAX - 1) begin
          srt[i] <= srt[i+1];
        end
      end else if (rd_vld && gt[i]) begin
        if (i == 0) begin
          srt[i] <= rd_data;
        end else if (!gt[i-1]) begin
          srt[i] <= rd_data;
        end else begin
          srt[i] <= srt[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < GATHER_MAX; i++) begin
      if (rst || clear_sorter) begin
        srt_vld[i] <= 1'b0;
      end else if (rd_vld) begin
        srt_vld[i] <= (i == 0) ? 1'b1 : (srt_vld[i] | srt_vld[i-1]);
      end
    end
  end

  // Median position and mean of the two middle values.
  assign mid = cnt >> 1;
  assign sum = {1'b0, lo} + {1'b0, srt[0]};

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
      cnt     <= '0;
      j       <= '0;
    end else begin
      if (state == ST_RESULT && (!m_valid || m_ready)) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_item.query) begin
            r0  <= q_item.r0;
            c0  <= q_item.c0;
            r1  <= q_item.r1;
            c1  <= q_item.c1;
            r   <= q_item.r0;
            c   <= q_item.c0;
            cnt <= '0;
            if (q_item.skip) begin
              med   <= '0;
              err   <= 1'b1;
              state <= ST_RESULT;
            end else begin
              err   <= 1'b0;
              state <= ST_GATHER;
            end
          end
        end
        ST_GATHER: begin
          cnt <= cnt + 1'b1;
          if (c == c1) begin
            c <= c0;
            r <= r + 1'b1;
            if (r == r1) begin
              state <= ST_DRAIN;
            end
          end else begin
            c <= c + 1'b1;
          end
        end
        ST_DRAIN: begin
          j     <= '0;
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          j <= j + 1'b1;
          if (j + 1'b1 == mid) begin
            lo <= srt[0];
          end
          if (j == mid) begin
            med   <= cnt[0] ? srt[0] : sum[PW:1];
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_valid || m_ready) begin
            m_median <= med;
            m_error  <= err;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The gather count never passes the sorter size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(GATHER_MAX))
    else $error("gather count above sorter size");

  // The two lowest filled entries are in order in the drain state.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && srt_vld[1]) |-> (srt[0] <= srt[1]))
    else $error("sorter entries out of order");

  // The queue is popped only while the sequencer is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE))
    else $error("queue popped while busy");

  // A coordinate error always carries a zero median.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_error) |-> (m_median == '0))
    else $error("error result with nonzero median");

endmodule

>>> rtl/clipped_window_median_filter.sv
// Top level of the clipped window median filter.
// Holds the configuration registers; uses cwmf_pkg, cwmf_front, cwmf_queue
// and cwmf_back.
//
//   Channel   Signals                        Carries
//   input     s_tvalid s_tready s_tdata s_tuser  load or query item
//   output    m_tvalid m_tready m_tdata m_tuser  one result per query
//   config    cfg_we cfg_addr cfg_data       register writes
//
// A load is written to the frame store from the idle state. A query
// gathers its pixels, drains and shifts before its result: the
// single read port of the frame store gives one pixel a cycle, then the
// sorted cells shift out to the median position. An error query skips them.
// Reset clears the queue, the sequencer and the registers; the frame store
// is not cleared. The input stalls only when the queue is full.
module clipped_window_median_filter #(
  parameter int MAX_WINDOW = cwmf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_ROWS   = cwmf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = cwmf_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row [5:0], col [11:6], pixel [19:12], zeros
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // median_value [7:0]
  output logic        m_tuser,   // coord_error
  input  logic        cfg_we,
  input  logic [cwmf_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [cwmf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [cwmf_pkg::WS_W-1:0]  window_size;
  logic [cwmf_pkg::DIM_W-1:0] image_rows;
  logic [cwmf_pkg::DIM_W-1:0] image_cols;
  cwmf_pkg::cwmf_item_t       front_item;
  cwmf_pkg::cwmf_item_t       head;
  logic                       full;
  logic                       not_empty;
  logic                       pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 3'd3;
      image_rows  <= 7'd64;
      image_cols  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cwmf_pkg::cfg_idx_t'(cfg_addr))
        cwmf_pkg::CFG_WINDOW_SIZE: window_size <= cfg_data[2:0];
        cwmf_pkg::CFG_IMAGE_ROWS:  image_rows  <= cfg_data;
        cwmf_pkg::CFG_IMAGE_COLS:  image_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !full;

  cwmf_front #(
    .MAX_WINDOW(MAX_WINDOW), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
  ) u_front (
    .window_size(window_size),
    .image_rows (image_rows),
    .image_cols (image_cols),
    .action     (s_tuser),
    .row        (s_tdata[5:0]),
    .col        (s_tdata[11:6]),
    .pixel      (s_tdata[19:12]),
    .item       (front_item)
  );

  cwmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s_tvalid),
    .push_item(front_item),
    .full     (full),
    .pop      (pop),
    .not_empty(not_empty),
    .head     (head)
  );

  cwmf_back #(
    .MAX_WINDOW(MAX_WINDOW), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (not_empty),
    .q_item  (head),
    .q_pop   (pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_median(m_tdata),
    .m_error (m_tuser)
  );

endmodule

>>> tb/tb_clipped_window_median_filter.sv
// Self-checking testbench for the clipped window median filter.
// Uses only cwmf_pkg and clipped_window_median_filter. It predicts each query result,
// steps through window and image settings, and varies idling on both stream sides.
module tb_clipped_window_median_filter;

  localparam int  CYCLE_LIMIT  = 1500000;
  localparam int  SETTLE       = 100;
  localparam int  STORE_SIDE   = 64;
  localparam logic [cwmf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam bit  OP_LOAD      = 1'b0;
  localparam bit  OP_QUERY     = 1'b1;

  typedef struct {
    bit       query;
    bit [5:0] row;
    bit [5:0] col;
    bit [7:0] pixel;
  } pixel_op_t;

  typedef struct {
    bit [7:0] median;
    bit       err;
  } filter_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // row [5:0], col [11:6], pixel [19:12], zeros
  logic        s_tuser;   // action
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // median_value [7:0]
  logic        m_tuser;   // coord_error
  logic        cfg_we;
  logic [cwmf_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [cwmf_pkg::CFG_DATA_W-1:0] cfg_data;

  // Register copies shared by the stimulus generator and the predictor.
  int unsigned win_reg;
  int unsigned rows_reg;
  int unsigned cols_reg;

  bit [7:0]       pixel_mem [STORE_SIDE*STORE_SIDE];
  bit             written   [STORE_SIDE*STORE_SIDE];
  pixel_op_t      op_queue[$];
  filter_result_t pending_medians[$];
  int             src_idle_pct;
  int             snk_idle_pct;
  int             errors;
  int             queries_checked;
  int             loads_sent;
  int             cycles;

  clipped_window_median_filter u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Clock and run limit.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_clipped_window_median_filter failed");
      $finish;
    end
  end

  // Median of the clipped window around one pixel under the current registers.
  function automatic filter_result_t window_median(bit [5:0] row, bit [5:0] col);
    int unsigned vals[$];
    int unsigned rows_used, cols_used, side, half, r0, r1, c0, c1, n;
    filter_result_t res;
    rows_used = (rows_reg > STORE_SIDE) ? STORE_SIDE : rows_reg;
    cols_used = (cols_reg > STORE_SIDE) ? STORE_SIDE : cols_reg;
    res.median = 8'd0;
    res.err    = 1'b1;
    if (row >= rows_used || col >= cols_used) return res;
    side = win_reg | 1;
    half = side / 2;
    r0 = (row >= half) ? row - half : 0;
    c0 = (col >= half) ? col - half : 0;
    r1 = (row + half > rows_used - 1) ? rows_used - 1 : row + half;
    c1 = (col + half > cols_used - 1) ? cols_used - 1 : col + half;
    for (int unsigned r = r0; r <= r1; r++)
      for (int unsigned c = c0; c <= c1; c++)
        vals.insert(vals.size(), 32'(pixel_mem[r*STORE_SIDE + c]));
    vals.sort();
    n = vals.size();
    res.err = 1'b0;
    if (n % 2) res.median = 8'(vals[n/2]);
    else res.median = 8'((vals[n/2-1] + vals[n/2]) / 2);
    return res;
  endfunction

  // Driver: the frame store copy and the expected results follow accepted transfers.
  always @(posedge clk) begin
    pixel_op_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_QUERY) begin
          pending_medians.insert(pending_medians.size(),
                                 window_median(s_tdata[5:0], s_tdata[11:6]));
        end else begin
          pixel_mem[s_tdata[5:0]*STORE_SIDE + s_tdata[11:6]] = s_tdata[19:12];
          loads_sent++;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (op_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = op_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.query;
          s_tdata  <= {4'b0, nxt.pixel, nxt.col, nxt.row};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order comparison of each result.
  always @(posedge clk) begin
    filter_result_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_medians.size() == 0) begin
          $error("result with no query outstanding: median_value %0d coord_error %0d",
                 m_tdata, m_tuser);
          errors++;
        end else begin
          exp_res = pending_medians.pop_front();
          queries_checked++;
          if (m_tdata !== exp_res.median) begin
            $error("median_value expected %0d actual %0d", exp_res.median, m_tdata);
            errors++;
          end
          if (m_tuser !== exp_res.err) begin
            $error("coord_error expected %0d actual %0d", exp_res.err, m_tuser);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic queue_load(bit [5:0] row, bit [5:0] col, bit [7:0] pixel);
    pixel_op_t op;
    op = '{OP_LOAD, row, col, pixel};
    written[col*STORE_SIDE + row] = 1'b1;
    op_queue.insert(op_queue.size(), op);
  endtask

  // Queues a query, first loading any pixel of its window that was never written.
  task automatic queue_query(bit [5:0] row, bit [5:0] col, bit extreme_fill);
    int unsigned rows_used, cols_used, half, r0, r1, c0, c1;
    pixel_op_t op;
    rows_used = (rows_reg > STORE_SIDE) ? STORE_SIDE : rows_reg;
    cols_used = (cols_reg > STORE_SIDE) ? STORE_SIDE : cols_reg;
    if (row < rows_used && col < cols_used) begin
      half = (win_reg | 1) / 2;
      r0 = (row >= half) ? row - half : 0;
      c0 = (col >= half) ? col - half : 0;
      r1 = (row + half > rows_used - 1) ? rows_used - 1 : row + half;
      c1 = (col + half > cols_used - 1) ? cols_used - 1 : col + half;
      for (int unsigned r = r0; r <= r1; r++)
        for (int unsigned c = c0; c <= c1; c++)
          if (!written[c*STORE_SIDE + r])
            queue_load(6'(r), 6'(c), extreme_fill ? ($urandom_range(1) ? 8'hff : 8'h00)
                                                  : 8'($urandom_range(255)));
    end
    op = '{OP_QUERY, row, col, 8'($urandom_range(255))};
    op_queue.insert(op_queue.size(), op);
  endtask

  // Waits for the block to drain, then writes the three registers.
  task automatic set_filter(int unsigned ws, int unsigned rows, int unsigned cols);
    wait (op_queue.size() == 0 && pending_medians.size() == 0 && !s_tvalid);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= cwmf_pkg::CFG_WINDOW_SIZE;
    cfg_data <= 7'(ws);
    @(posedge clk);
    cfg_addr <= cwmf_pkg::CFG_IMAGE_ROWS;
    cfg_data <= 7'(rows);
    @(posedge clk);
    cfg_addr <= cwmf_pkg::CFG_IMAGE_COLS;
    cfg_data <= 7'(cols);
    @(posedge clk);
    cfg_we   <= 1'b0;
    win_reg  = ws & 7;
    rows_reg = rows & 127;
    cols_reg = cols & 127;
  endtask

  // Random mix: loads anywhere, queries mostly inside the image.
  task automatic random_phase(int count);
    int unsigned rows_used, cols_used, start;
    bit [5:0] row, col;
    rows_used = (rows_reg > STORE_SIDE) ? STORE_SIDE : rows_reg;
    cols_used = (cols_reg > STORE_SIDE) ? STORE_SIDE : cols_reg;
    start = op_queue.size();
    while (op_queue.size() - start < count) begin
      if ($urandom_range(99) < 25) begin
        queue_load(6'($urandom_range(63)), 6'($urandom_range(63)),
                   8'($urandom_range(255)));
      end else begin
        if (rows_used > 0 && cols_used > 0 && $urandom_range(99) < 85) begin
          row = 6'($urandom_range(rows_used - 1));
          col = 6'($urandom_range(cols_used - 1));
        end else begin
          row = 6'($urandom_range(63));
          col = 6'($urandom_range(63));
        end
        queue_query(row, col, $urandom_range(3) == 0);
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned ws_list[12]   = '{1, 0, 7, 2, 5, 4, 6, 7, 3, 7, 6, 5};
    int unsigned rows_list[12] = '{8, 5, 8, 1, 3, 0, 127, 10, 64, 6, 127, 64};
    int unsigned cols_list[12] = '{8, 7, 8, 1, 64, 10, 127, 0, 2, 6, 1, 64};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = cwmf_pkg::CFG_WINDOW_SIZE;
    cfg_data = '0;
    win_reg = 3;
    rows_reg = 64;
    cols_reg = 64;
    errors = 0;
    cycles = 0;
    queries_checked = 0;
    loads_sent = 0;
    src_idle_pct = 7;
    snk_idle_pct = 81;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A write to the unused register index must change nothing.
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_UNUSED;
    cfg_data <= 7'h7f;
    @(posedge clk);
    cfg_we   <= 1'b0;

    // Directed: corner windows with extreme pixels give even counts.
    queue_load(0, 0, 8'h00);
    queue_load(0, 1, 8'hff);
    queue_load(1, 0, 8'hff);
    queue_load(1, 1, 8'h00);
    queue_query(0, 0, 1'b1);
    queue_query(63, 63, 1'b1);
    queue_query(0, 63, 1'b0);
    queue_query(63, 0, 1'b1);
    queue_query(32, 21, 1'b0);
    queue_load(0, 0, 8'hff);
    queue_query(0, 0, 1'b0);
    queue_query(1, 1, 1'b0);
    set_filter(7, 1, 1);
    queue_query(0, 0, 1'b0);
    queue_query(0, 1, 1'b0);
    queue_query(63, 0, 1'b0);
    set_filter(2, 0, 64);
    queue_query(0, 0, 1'b0);
    queue_query(42, 21, 1'b0);

    // Random phases under changing settings and idling.
    for (int p = 0; p < 12; p++) begin
      set_filter(ws_list[p], rows_list[p], cols_list[p]);
      if (p == 4) begin
        src_idle_pct = 81;
        snk_idle_pct = 7;
      end else if (p == 8) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      random_phase(118);
    end

    wait (op_queue.size() == 0 && pending_medians.size() == 0 && !s_tvalid);
    repeat (SETTLE) @(posedge clk);
    $display("Ran %0d loads and checked %0d query results over 15 register settings,",
             loads_sent, queries_checked);
    $display("with idling on the input side, on the output side and on neither.");
    if (errors == 0 && pending_medians.size() == 0) begin
      $display("tb_clipped_window_median_filter passed");
    end else begin
      $display("tb_clipped_window_median_filter failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cwmf_pkg.sv
rtl/cwmf_front.sv
rtl/cwmf_queue.sv
rtl/cwmf_back.sv
rtl/clipped_window_median_filter.sv
tb/tb_clipped_window_median_filter.sv
